// ----- sv/lfupr_pkg.sv -----
// ----------------------------------------------------------------------------
// lfupr_pkg: shared types and constants of the LFU page replacement unit
// Sizes of the page store, the cell command and the cell chain word.
// ----------------------------------------------------------------------------
`default_nettype none
package lfupr_pkg;
	localparam int ENTRIES     = 64;
	localparam int IDX_W       = 6;
	localparam int OCC_W       = 7;
	localparam int FREQ_LEVELS = 16;
	localparam int CNT_W       = 5;
	localparam int PAGE_BITS   = 48;
	localparam int CAP_W       = 7;

	typedef enum logic [1:0] {
		K_NONE   = 2'd0,
		K_HIT    = 2'd1,
		K_INS    = 2'd2,
		K_INS_EV = 2'd3
	} kind_t;

	typedef struct packed {
		logic                 apply;
		kind_t                kind;
		logic [PAGE_BITS-1:0] page;
		logic [CNT_W-1:0]     c_old;
		logic [IDX_W-1:0]     r_old;
		logic [CNT_W-1:0]     c_new;
		logic [IDX_W-1:0]     new_rank;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic free;
		logic vic;
	} sel_t;

	typedef struct packed {
		logic                 free;
		logic [PAGE_BITS-1:0] page;
		logic [CNT_W-1:0]     cnt;
		logic [IDX_W-1:0]     rank;
	} chain_t;
endpackage
`default_nettype wire

// ----- sv/lfupr_cell.sv -----
// ----------------------------------------------------------------------------
// lfupr_cell: one entry of the page store
// Holds page, use count and age rank; compares against the broadcast page,
// applies the broadcast update and passes the chain word to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none
module lfupr_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  lfupr_pkg::cmd_t         cmd,
	input  lfupr_pkg::sel_t         sel,
	input  lfupr_pkg::chain_t       chain_i,
	output lfupr_pkg::chain_t       chain_o,
	output logic                    match,
	output logic                    first_free,
	output logic                    vic_cand
);
	logic                            valid_q;
	logic [lfupr_pkg::PAGE_BITS-1:0] page_q;
	logic [lfupr_pkg::CNT_W-1:0]     count_q;
	logic [lfupr_pkg::IDX_W-1:0]     rank_q;
	logic                            dec;

	assign match      = valid_q && (page_q == cmd.page);
	assign vic_cand   = valid_q && (count_q == lfupr_pkg::CNT_W'(1)) && (rank_q == '0);
	assign first_free = !valid_q && !chain_i.free;
	assign dec        = valid_q && (count_q == cmd.c_old) && (rank_q > cmd.r_old);

	always_comb begin
		chain_o.free = chain_i.free | ~valid_q;
		chain_o.page = chain_i.page | (sel.vic ? page_q : '0);
		chain_o.cnt  = chain_i.cnt | (match ? count_q : '0);
		chain_o.rank = chain_i.rank | (match ? rank_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.apply) begin
			if ((cmd.kind == lfupr_pkg::K_INS || cmd.kind == lfupr_pkg::K_INS_EV)
			    && sel.free) begin
				valid_q <= 1'b1;
			end else if (cmd.kind == lfupr_pkg::K_INS_EV && sel.vic) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			case (cmd.kind)
				lfupr_pkg::K_HIT: begin
					if (sel.hit) begin
						count_q <= cmd.c_new;
						rank_q  <= cmd.new_rank;
					end else if (dec) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				lfupr_pkg::K_INS, lfupr_pkg::K_INS_EV: begin
					if (sel.free) begin
						page_q  <= cmd.page;
						count_q <= lfupr_pkg::CNT_W'(1);
						rank_q  <= cmd.new_rank;
					end else if (cmd.kind == lfupr_pkg::K_INS_EV && !sel.vic && dec) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- sv/lfu_page_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit: LFU page store with oldest-first tie-break
// Row of 64 entry cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one request word: s_tdata = page, s_tuser = req_type
//   (1 = write, ignored). m_* channel returns one result word per request.
//   cfg_* writes the capacity register (occupancy at which a miss evicts).
// Sequence: the sequencer steps through idle, look and update. Idle takes
//   the request word; look runs the tag compare across the cell row (which
//   also finds the first free cell, the hit entry's count and rank, and the
//   eviction candidate); update broadcasts the update to the cells and loads
//   the output register. This three-step sequencer takes no new request
//   word until it is back in idle, so requests do not overlap.
// The output register decouples the sides: a new request is accepted while
//   a result waits; if the receiver stalls, the update step holds until the
//   output register is free.
// Reset clears all valid bits, the per-count list sizes and occupancy, and
//   sets capacity to 64. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module lfu_page_replacement_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // page[47:0]
	input  wire  [0:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [55:0] m_tdata,   // hit, evicted, victim_page[47:0], zero pad
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [6:0]  cfg_data   // capacity
);
	localparam int E  = lfupr_pkg::ENTRIES;
	localparam int PB = lfupr_pkg::PAGE_BITS;
	localparam int CW = lfupr_pkg::CNT_W;
	localparam int IW = lfupr_pkg::IDX_W;
	localparam int OW = lfupr_pkg::OCC_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t                   state_q;
	logic [lfupr_pkg::CAP_W-1:0] capacity_q;
	logic                     wr_q;
	logic [PB-1:0]            page_q;
	logic [E-1:0]             hit_vec_q, free_vec_q, vic_vec_q;
	logic                     hit_q;
	logic [CW-1:0]            c_old_q;
	logic [IW-1:0]            r_old_q;
	logic [OW-1:0]            size_q [0:lfupr_pkg::FREQ_LEVELS];
	logic [OW-1:0]            occ_q;
	logic                     out_valid_q;
	logic [55:0]              out_data_q;

	logic [E-1:0]             match_vec, first_free_vec, vic_cand_vec;
	lfupr_pkg::chain_t        chain [0:E];
	lfupr_pkg::cmd_t          cmd;
	logic                     upd_go;
	logic [CW-1:0]            c_new;
	logic [OW-1:0]            cap;
	logic                     need_ev;
	logic                     ev_new;
	logic [55:0]              res_data;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	assign upd_go  = (state_q == ST_UPD) && (!out_valid_q || m_tready);
	assign c_new   = (c_old_q == CW'(lfupr_pkg::FREQ_LEVELS)) ? c_old_q : c_old_q + 1'b1;
	assign cap     = (capacity_q > OW'(E)) ? OW'(E) : OW'(capacity_q);
	assign need_ev = ({1'b0, occ_q} + 1'b1) >= {1'b0, cap};
	assign ev_new  = need_ev && (size_q[1] == '0);

	assign chain[0] = '0;

	always_comb begin
		cmd.apply    = upd_go && !wr_q;
		cmd.page     = page_q;
		cmd.c_old    = c_old_q;
		cmd.r_old    = r_old_q;
		cmd.c_new    = c_new;
		cmd.kind     = lfupr_pkg::K_NONE;
		cmd.new_rank = '0;
		if (hit_q) begin
			cmd.kind     = lfupr_pkg::K_HIT;
			cmd.new_rank = (c_new == c_old_q) ? IW'(size_q[c_old_q] - 1'b1)
			                                  : IW'(size_q[c_new]);
		end else if (need_ev) begin
			// evict oldest count-1 page, or drop the new page if it would be alone
			cmd.kind     = ev_new ? lfupr_pkg::K_NONE : lfupr_pkg::K_INS_EV;
			cmd.c_old    = CW'(1);
			cmd.r_old    = '0;
			cmd.new_rank = IW'(size_q[1] - 1'b1);
		end else begin
			cmd.kind     = lfupr_pkg::K_INS;
			cmd.new_rank = IW'(size_q[1]);
		end
	end

	always_comb begin
		res_data = '0;
		if (!wr_q) begin
			if (hit_q) begin
				res_data[0] = 1'b1;
			end else if (need_ev) begin
				res_data[1]    = 1'b1;
				res_data[49:2] = ev_new ? page_q : chain[E].page;
			end
		end
	end

	for (genvar g = 0; g < E; g++) begin : g_cell
		lfupr_pkg::sel_t sel;
		assign sel.hit  = hit_vec_q[g];
		assign sel.free = free_vec_q[g];
		assign sel.vic  = vic_vec_q[g];
		lfupr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.sel       (sel),
			.chain_i   (chain[g]),
			.chain_o   (chain[g+1]),
			.match     (match_vec[g]),
			.first_free(first_free_vec[g]),
			.vic_cand  (vic_cand_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			capacity_q  <= lfupr_pkg::CAP_W'(64);
			occ_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= lfupr_pkg::FREQ_LEVELS; i++) begin
				size_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				capacity_q <= cfg_data;
			end
			// load a new word, or drop the one taken by the receiver
			if (upd_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (s_tvalid) state_q <= ST_LOOK;
				ST_LOOK: state_q <= ST_UPD;
				ST_UPD: begin
					if (upd_go) begin
						state_q <= ST_IDLE;
						if (!wr_q) begin
							if (hit_q) begin
								if (c_new != c_old_q) begin
									size_q[c_old_q] <= size_q[c_old_q] - 1'b1;
									size_q[c_new]   <= size_q[c_new] + 1'b1;
								end
							end else if (!need_ev) begin
								size_q[1] <= size_q[1] + 1'b1;
								occ_q     <= occ_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			wr_q   <= s_tuser[0];
			page_q <= s_tdata;
		end
		if (state_q == ST_LOOK) begin
			hit_vec_q  <= match_vec;
			hit_q      <= |match_vec;
			c_old_q    <= chain[E].cnt;
			r_old_q    <= chain[E].rank;
			free_vec_q <= first_free_vec;
			vic_vec_q  <= vic_cand_vec;
		end
		if (upd_go) begin
			out_data_q <= res_data;
		end
	end
endmodule
`default_nettype wire

// ----- tb/sv/lfu_page_replacement_unit_tb.sv -----
// ----------------------------------------------------------------------------
// lfu_page_replacement_unit_tb: self-checking bench of the LFU page store
// Streams page requests with random idling on both sides, predicts each
// result word with a behavioral page store and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module lfu_page_replacement_unit_tb;
	typedef struct packed {
		logic                            is_write;
		logic [lfupr_pkg::PAGE_BITS-1:0] page;
	} req_t;

	typedef struct packed {
		logic                            hit;
		logic                            evicted;
		logic [lfupr_pkg::PAGE_BITS-1:0] victim;
	} resp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;

	lfu_page_replacement_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// page store shadow
	logic                            sh_valid [lfupr_pkg::ENTRIES];
	logic [lfupr_pkg::PAGE_BITS-1:0] sh_page  [lfupr_pkg::ENTRIES];
	int                              sh_count [lfupr_pkg::ENTRIES];
	int                              sh_rank  [lfupr_pkg::ENTRIES];
	int                              sh_capacity;

	req_t  pending_reqs[$];
	resp_t expected_resps[$];
	int    errors = 0;
	bit    no_idle;
	bit    cfg_busy;
	logic [6:0] cfg_value;
	int    send_gap;
	int    recv_gap;

	always #5 clk = ~clk;

	function automatic void unlink(int i);
		for (int j = 0; j < lfupr_pkg::ENTRIES; j++)
			if (j != i && sh_valid[j] && sh_count[j] == sh_count[i] && sh_rank[j] > sh_rank[i])
				sh_rank[j]--;
	endfunction

	function automatic void link_newest(int i, int c);
		int n;
		n = 0;
		for (int j = 0; j < lfupr_pkg::ENTRIES; j++)
			if (j != i && sh_valid[j] && sh_count[j] == c)
				n++;
		sh_count[i] = c;
		sh_rank[i] = n;
	endfunction

	function automatic resp_t access_page(req_t r);
		resp_t res;
		int found, slot, best, occ, cap;
		res = '0;
		found = -1;
		slot = -1;
		best = -1;
		occ = 0;
		if (r.is_write)
			return res;
		for (int i = 0; i < lfupr_pkg::ENTRIES; i++)
			if (found < 0 && sh_valid[i] && sh_page[i] == r.page)
				found = i;
		if (found >= 0) begin
			unlink(found);
			link_newest(found, sh_count[found] < lfupr_pkg::FREQ_LEVELS ? sh_count[found] + 1
				: lfupr_pkg::FREQ_LEVELS);
			res.hit = 1'b1;
			return res;
		end
		for (int i = 0; i < lfupr_pkg::ENTRIES; i++)
			if (slot < 0 && !sh_valid[i])
				slot = i;
		if (slot < 0)
			return res;
		sh_valid[slot] = 1'b1;
		sh_page[slot] = r.page;
		link_newest(slot, 1);
		for (int i = 0; i < lfupr_pkg::ENTRIES; i++)
			if (sh_valid[i])
				occ++;
		cap = sh_capacity > lfupr_pkg::ENTRIES ? lfupr_pkg::ENTRIES : sh_capacity;
		if (occ < cap)
			return res;
		for (int i = 0; i < lfupr_pkg::ENTRIES; i++) begin
			if (!sh_valid[i])
				continue;
			if (best < 0 || sh_count[i] < sh_count[best] ||
			    (sh_count[i] == sh_count[best] && sh_rank[i] < sh_rank[best]))
				best = i;
		end
		unlink(best);
		sh_valid[best] = 1'b0;
		res.evicted = 1'b1;
		res.victim = sh_page[best];
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				req_t r;
				r = pending_reqs.pop_front();
				expected_resps.insert(expected_resps.size(), access_page(r));
				s_tvalid <= 1'b1;
				s_tdata <= r.page;
				s_tuser <= r.is_write;
				if (!no_idle && $urandom_range(0, 9) == 0)
					send_gap <= $urandom_range(1, 18);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				resp_t want;
				if (expected_resps.size() == 0) begin
					$display("%0t: unexpected word %h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_resps.pop_front();
					if (m_tdata[0] !== want.hit) begin
						$display("%0t: hit expected %0b actual %0b", $time, want.hit, m_tdata[0]);
						errors++;
					end
					if (m_tdata[1] !== want.evicted) begin
						$display("%0t: evicted expected %0b actual %0b", $time, want.evicted,
							m_tdata[1]);
						errors++;
					end
					if (m_tdata[49:2] !== want.victim) begin
						$display("%0t: victim_page expected %h actual %h", $time, want.victim,
							m_tdata[49:2]);
						errors++;
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(1, 18);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// config channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_data <= '0;
		end else if (cfg_valid && cfg_ready)
			cfg_valid <= 1'b0;
		else if (cfg_busy && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_data <= cfg_value;
		end
	end

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || expected_resps.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_capacity(logic [6:0] v);
		wait_drained();
		cfg_value = v;
		cfg_busy = 1'b1;
		@(posedge clk);
		while (!(cfg_valid && cfg_ready))
			@(posedge clk);
		cfg_busy = 1'b0;
		sh_capacity = v;
		@(posedge clk);
	endtask

	task automatic push_req(logic w, logic [lfupr_pkg::PAGE_BITS-1:0] p);
		req_t r;
		r.is_write = w;
		r.page = p;
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// reuse a small working set so hits, saturation and evictions all occur
	task automatic random_phase(int n, int span);
		logic [lfupr_pkg::PAGE_BITS-1:0] base;
		base = lfupr_pkg::PAGE_BITS'({$urandom, $urandom});
		for (int k = 0; k < n; k++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 5)
				push_req(1'b1, lfupr_pkg::PAGE_BITS'({$urandom, $urandom}));
			else if (pick < 10)
				push_req(1'b0, lfupr_pkg::PAGE_BITS'({$urandom, $urandom}));
			else if (pick < 60)
				push_req(1'b0, base ^ lfupr_pkg::PAGE_BITS'($urandom_range(0, 3)));
			else
				push_req(1'b0, base ^ lfupr_pkg::PAGE_BITS'($urandom_range(0, span)));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_value = '0;
		cfg_busy = 1'b0;
		no_idle = 1'b0;
		sh_capacity = 64;
		for (int i = 0; i < lfupr_pkg::ENTRIES; i++)
			sh_valid[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, writes, hits, saturated count
		push_req(1'b0, '0);
		push_req(1'b0, '1);
		push_req(1'b1, '1);
		push_req(1'b1, '0);
		push_req(1'b0, '0);
		for (int k = 0; k < 18; k++)
			push_req(1'b0, 48'h5555_aaaa_5555);
		set_capacity(7'd1);
		push_req(1'b0, 48'h1234);
		push_req(1'b0, 48'h1234);
		set_capacity(7'd0);
		push_req(1'b0, 48'h9);
		set_capacity(7'd3);
		push_req(1'b0, 48'h10);
		push_req(1'b0, 48'h11);
		push_req(1'b0, 48'h12);

		set_capacity(7'd127);
		random_phase(250, 127);
		set_capacity(7'd2);
		random_phase(150, 7);
		set_capacity(7'd64);
		random_phase(250, 100);
		set_capacity(7'd65);
		random_phase(200, 90);
		set_capacity(7'd8);
		random_phase(200, 20);
		set_capacity(7'd5);
		no_idle = 1'b1;
		random_phase(150, 12);
		wait_drained();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
